// File: rtl/core/grr_pkg.sv
// grr_pkg: shared types and constants for the glyph row renderer.
// Used by grr_front, grr_back and glyph_row_renderer_top; no dependencies.
package grr_pkg;

    localparam int ROW_BITS   = 16;
    localparam int COORD_W    = 12;
    localparam int CFG_DATA_W = 9;
    localparam int CMD_ADDR_W = 13;   // enough for 256 symbols x 32 rows

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GLYPH_WIDTH  = 2'd0,
        CFG_GLYPH_HEIGHT = 2'd1,
        CFG_SYMBOL_COUNT = 2'd2
    } t_cfg_index;

    localparam logic FUNC_RENDER = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  char_code;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [3:0]  glyph_line;
        logic [15:0] line_bits;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [ROW_BITS-1:0] row_mask;
        logic                last_row;
    } t_result;

    // clamped, ready-to-use configuration
    typedef struct packed {
        logic [ROW_BITS-1:0] row_mask;
        logic [4:0]          height;
        logic [4:0]          width;
        logic [8:0]          count;
    } t_cfg;

    typedef enum logic {
        CMD_RENDER = 1'b0,
        CMD_LOAD   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [CMD_ADDR_W-1:0] addr;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [ROW_BITS-1:0] bits;
    } t_cmd;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_RENDER = 1'b1
    } t_back_state;

    typedef struct packed {
        logic rendering;
        logic rd_pending;
    } t_back_status;

    // top w bits set, w in 1..16
    function automatic logic [ROW_BITS-1:0] width_mask(input logic [4:0] w);
        logic [ROW_BITS-1:0] ones;
        ones = '1;
        return ones << (5'(ROW_BITS) - w);
    endfunction

endpackage

// File: rtl/core/grr_fifo.sv
// grr_fifo: small synchronous FIFO, register storage, power-of-two depth.
// No package dependencies.
module grr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/grr_front.sv
// grr_front: accepts input transactions, drops skipped ones and builds
// back-end commands. Depends on grr_pkg.
module grr_front #(
    parameter int MAX_GLYPH_HEIGHT = 16,
    parameter int MAX_SYMBOLS      = 256,
    parameter int MAX_COLS         = 256,
    parameter int MAX_ROWS         = 256
) (
    input  grr_pkg::t_in_item i_item,
    input  logic              i_push,
    input  grr_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output grr_pkg::t_cmd     o_cmd
);

    localparam int AW = grr_pkg::CMD_ADDR_W;
    localparam int CW = grr_pkg::COORD_W;

    logic          load_ok;
    logic          render_ok;
    logic          keep;
    logic [AW-1:0] base;

    always_comb begin
        load_ok   = (int'(i_item.char_code) < MAX_SYMBOLS) &&
                    (int'(i_item.glyph_line) < MAX_GLYPH_HEIGHT);
        render_ok = ({1'b0, i_item.char_code} < i_cfg.count) &&
                    (int'(i_item.cell_col) < MAX_COLS) &&
                    (int'(i_item.cell_row) < MAX_ROWS);
        keep      = (i_item.func == grr_pkg::FUNC_LOAD) ? load_ok : render_ok;
        base      = AW'(int'(i_item.char_code) * MAX_GLYPH_HEIGHT);

        o_cmd.kind = (i_item.func == grr_pkg::FUNC_LOAD) ? grr_pkg::CMD_LOAD
                                                          : grr_pkg::CMD_RENDER;
        o_cmd.addr = (i_item.func == grr_pkg::FUNC_LOAD)
                   ? base + AW'(i_item.glyph_line) : base;
        // coordinates wrap to 12 bits
        o_cmd.x    = CW'({5'b0, i_item.cell_col} * {8'b0, i_cfg.width});
        o_cmd.y    = CW'({5'b0, i_item.cell_row} * {8'b0, i_cfg.height});
        o_cmd.bits = i_item.line_bits;
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push & ~i_q_full & keep;

endmodule

// File: rtl/core/grr_back.sv
// grr_back: executes commands against the font memory; one glyph row per
// cycle for renders while the result FIFO has room. Depends on grr_pkg.
module grr_back #(
    parameter int MAX_GLYPH_HEIGHT = 16,
    parameter int MAX_SYMBOLS      = 256,
    parameter int RES_DEPTH        = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grr_pkg::t_cfg                  i_cfg,
    input  grr_pkg::t_cmd                  i_cmd,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0] i_res_count,
    output logic                           o_res_push,
    output grr_pkg::t_result               o_res,
    output grr_pkg::t_back_status          o_status
);

    localparam int STORE_DEPTH = MAX_SYMBOLS * MAX_GLYPH_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW          = grr_pkg::COORD_W;

    logic [grr_pkg::ROW_BITS-1:0] r_font [STORE_DEPTH];

    grr_pkg::t_back_state r_state, n_state;
    grr_pkg::t_cmd        r_cmd, n_cmd;
    logic [3:0]           r_gy, n_gy;

    logic                         r_rd_vld;
    logic [grr_pkg::ROW_BITS-1:0] r_rd_data;
    logic [CW-1:0]                r_rd_x;
    logic [CW-1:0]                r_rd_y;
    logic                         r_rd_last;

    logic              mem_we;
    logic              rd_en;
    logic              is_last;
    logic              credit_ok;
    logic [ADDR_W-1:0] rd_addr;

    assign is_last   = (({1'b0, r_gy} + 5'd1) == i_cfg.height);
    assign credit_ok = (int'(i_res_count) + int'(r_rd_vld)) < RES_DEPTH;
    assign rd_addr   = r_cmd.addr[ADDR_W-1:0] + ADDR_W'(r_gy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= grr_pkg::BK_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_gy  <= n_gy;
        if (rd_en) begin
            r_rd_x    <= r_cmd.x;
            r_rd_y    <= r_cmd.y + CW'(r_gy);
            r_rd_last <= is_last;
        end
    end

    // font memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_font[i_cmd.addr[ADDR_W-1:0]] <= i_cmd.bits;
        end
        if (rd_en) begin
            r_rd_data <= r_font[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_gy    = r_gy;
        o_q_pop = 1'b0;
        mem_we  = 1'b0;
        rd_en   = 1'b0;
        unique case (r_state)
            grr_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_cmd.kind == grr_pkg::CMD_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        n_cmd   = i_cmd;
                        n_gy    = '0;
                        n_state = grr_pkg::BK_RENDER;
                    end
                end
            end
            grr_pkg::BK_RENDER: begin
                if (credit_ok) begin
                    rd_en = 1'b1;
                    n_gy  = r_gy + 4'd1;
                    if (is_last) begin
                        n_state = grr_pkg::BK_IDLE;
                    end
                end
            end
            default: n_state = grr_pkg::BK_IDLE;
        endcase
    end

    assign o_res_push        = r_rd_vld;
    assign o_res.pixel_x     = r_rd_x;
    assign o_res.pixel_y     = r_rd_y;
    assign o_res.row_mask    = r_rd_data & i_cfg.row_mask;
    assign o_res.last_row    = r_rd_last;
    assign o_status.rendering  = (r_state == grr_pkg::BK_RENDER);
    assign o_status.rd_pending = r_rd_vld;

endmodule

// File: rtl/core/glyph_row_renderer_top.sv
// glyph_row_renderer_top: text-mode character generator top level.
// Depends on grr_pkg, grr_fifo, grr_front and grr_back.
//
// Queue-style ports on both sides. A transaction is either a font load
// (func = load: writes one 16-bit glyph row, no result) or a character render
// (one result per glyph row, last_row set on the final one). Renders with a
// code at or above symbol_count, or a cell outside MAX_COLS x MAX_ROWS, and
// loads outside the font store are dropped with no result. The front end takes
// one transaction per cycle while its 4-entry command queue has room. The back
// end owns the font memory (MAX_SYMBOLS * MAX_GLYPH_HEIGHT rows): a load is
// written as its command is taken; a render takes the command, then does one
// memory read per row, and no new command is taken until its last row is read.
// The first row of a render passes the command queue, the command register,
// the font read register and the result FIFO on its way to the result ports;
// the 4-entry result FIFO decouples the consumer, and the back end stalls only
// when that FIFO has no room. The font memory is not cleared: rows must be
// loaded before they are rendered. Configuration registers are plain writes
// and must only change while the block is idle.
module glyph_row_renderer_top #(
    parameter int MAX_GLYPH_WIDTH  = 16,
    parameter int MAX_GLYPH_HEIGHT = 16,
    parameter int MAX_SYMBOLS      = 256,
    parameter int MAX_COLS         = 256,
    parameter int MAX_ROWS         = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input queue
    input  logic                               push,
    output logic                               full,
    input  grr_pkg::t_in_item                  i_item,
    // result queue
    output logic                               empty,
    input  logic                               pop,
    output grr_pkg::t_result                   o_result,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [grr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
    localparam int WIDTH_LIM  = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
    localparam int HEIGHT_LIM = (MAX_GLYPH_HEIGHT < 16) ? MAX_GLYPH_HEIGHT : 16;

    // ---- configuration registers ----
    logic [4:0] r_glyph_width;
    logic [4:0] r_glyph_height;
    logic [8:0] r_symbol_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= 5'd8;
            r_glyph_height <= 5'd16;
            r_symbol_count <= 9'd128;
        end else if (i_cfg_we) begin
            unique case (grr_pkg::t_cfg_index'(i_cfg_index))
                grr_pkg::CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[4:0];
                grr_pkg::CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[4:0];
                grr_pkg::CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Clamp to legal ranges: a zero width or height counts as one, oversize as the limit.
    grr_pkg::t_cfg cfg;

    always_comb begin
        if (r_glyph_width == '0) begin
            cfg.width = 5'd1;
        end else if (int'(r_glyph_width) > WIDTH_LIM) begin
            cfg.width = 5'(WIDTH_LIM);
        end else begin
            cfg.width = r_glyph_width;
        end
        if (r_glyph_height == '0) begin
            cfg.height = 5'd1;
        end else if (int'(r_glyph_height) > HEIGHT_LIM) begin
            cfg.height = 5'(HEIGHT_LIM);
        end else begin
            cfg.height = r_glyph_height;
        end
        cfg.count    = (int'(r_symbol_count) > MAX_SYMBOLS) ? 9'(MAX_SYMBOLS)
                                                            : r_symbol_count;
        cfg.row_mask = grr_pkg::width_mask(cfg.width);
    end

    // ---- front end: classify and build commands ----
    grr_pkg::t_cmd cmd_in;
    grr_pkg::t_cmd cmd_out;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;

    grr_front #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .MAX_SYMBOLS      (MAX_SYMBOLS),
        .MAX_COLS         (MAX_COLS),
        .MAX_ROWS         (MAX_ROWS)
    ) u_front (
        .i_item   (i_item),
        .i_push   (push),
        .i_cfg    (cfg),
        .i_q_full (cmd_full),
        .o_full   (full),
        .o_q_push (cmd_push),
        .o_cmd    (cmd_in)
    );

    // ---- command queue between front and back ----
    grr_fifo #(
        .WIDTH ($bits(grr_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    // ---- back end: font memory and row sequencer ----
    grr_pkg::t_result      res_in;
    logic                  res_push;
    logic                  res_full;
    logic [RES_CNT_W-1:0]  res_count;
    grr_pkg::t_back_status bk_status;

    grr_back #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .MAX_SYMBOLS      (MAX_SYMBOLS),
        .RES_DEPTH        (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd_out),
        .i_q_empty   (cmd_empty),
        .o_q_pop     (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_status    (bk_status)
    );

    // ---- result queue ----
    grr_fifo #(
        .WIDTH ($bits(grr_pkg::t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (res_full),
        .o_empty (empty),
        .o_count (res_count)
    );

    // ---- assertions ----
    // back-end credit check must keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result queue written while full");

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue written while full");

    // no result can appear unless a row read was in flight
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!bk_status.rendering && !bk_status.rd_pending) |=> !res_push)
        else $error("result produced with no row read pending");

    // the final row of a character leaves the sequencer idle
    a_last_ends_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_in.last_row) |-> !bk_status.rendering)
        else $error("last row delivered while still rendering");

endmodule

// File: tb/sv/glyph_row_renderer_top_tb.sv
// glyph_row_renderer_top_tb: self-checking testbench for the glyph row renderer.
// Drives font loads and character renders, predicts every glyph row in-house.
// Depends on grr_pkg and glyph_row_renderer_top.
module glyph_row_renderer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the instance (default parameters of the block)
    localparam int MAX_W   = 16;
    localparam int MAX_H   = 16;
    localparam int MAX_SYM = 256;

    localparam int ROW_BITS   = grr_pkg::ROW_BITS;
    localparam int COORD_W    = grr_pkg::COORD_W;
    localparam int CFG_DATA_W = grr_pkg::CFG_DATA_W;

    // register index 3 decodes to nothing; writes to it must be ignored
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // cycles to let loads still in flight finish once results have stopped:
    // 4-entry command queue plus a render in the back end, with margin
    localparam int SETTLE_CYCLES = 40;
    // run cap, sized for renders of 16 rows under stall bursts on both sides
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 76;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    grr_pkg::t_in_item     i_item      = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    grr_pkg::t_result      o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    glyph_row_renderer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state: raw register values as written and a copy of the font
    // memory. Updated only at transaction acceptance or while idle.
    // ------------------------------------------------------------------
    logic [4:0]  width_reg  = 5'd8;
    logic [4:0]  height_reg = 5'd16;
    logic [8:0]  count_reg  = 9'd128;
    logic [15:0] font_model [MAX_SYM*MAX_H];
    // rows that the stimulus has already queued a load for; a valid render is
    // only generated once every row it will read has a load queued ahead of it
    bit          font_ready [MAX_SYM*MAX_H];

    grr_pkg::t_in_item pending_items [$];   // transactions waiting for the driver
    grr_pkg::t_result  glyph_rows_due [$];  // predicted rows, oldest first

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  renders_sent   = 0;
    int  rows_checked   = 0;
    int  errors         = 0;
    int  cycle_count    = 0;
    int  phases_run     = 0;
    bit  input_taken    = 1'b0;    // handshake seen at the last rising edge
    int  send_gap       = 0;
    int  pop_stall      = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;

    // clock: 2 ns period
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still due",
                     cycle_count, glyph_rows_due.size());
            $display("** glyph_row_renderer_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Effective settings: out-of-range register values are clamped.
    // ------------------------------------------------------------------
    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_H) return MAX_H;
        return int'(height_reg);
    endfunction

    function automatic int eff_count();
        if (count_reg > MAX_SYM) return MAX_SYM;
        return int'(count_reg);
    endfunction

    // Row predictor: a load updates the font copy, a render of a valid code
    // queues one row per glyph line, last_row on the final one.
    function automatic void predict_glyph_rows(grr_pkg::t_in_item it);
        int               w;
        int               h;
        int               base;
        logic [15:0]      mask;
        grr_pkg::t_result row;
        base = int'(it.char_code) * MAX_H;
        if (it.func == grr_pkg::FUNC_LOAD) begin
            font_model[base + int'(it.glyph_line)] = it.line_bits;
            return;
        end
        w = eff_width();
        h = eff_height();
        if (int'(it.char_code) >= eff_count()) return;
        mask = 16'(32'hFFFF << (ROW_BITS - w));
        for (int gy = 0; gy < h; gy++) begin
            row.pixel_x  = COORD_W'(int'(it.cell_col) * w);
            row.pixel_y  = COORD_W'(int'(it.cell_row) * h + gy);
            row.row_mask = font_model[base + gy] & mask;
            row.last_row = (gy == h - 1);
            glyph_rows_due.push_back(row);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge. An accepted
    // input transaction feeds the predictor; an accepted result is checked
    // against the oldest predicted row.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        grr_pkg::t_result want;
        input_taken = push && !full;
        if (i_rst_n) begin
            if (input_taken) begin
                items_accepted++;
                if (i_item.func == grr_pkg::FUNC_RENDER) renders_sent++;
                predict_glyph_rows(i_item);
            end
            if (pop && !empty) begin
                rows_checked++;
                if (glyph_rows_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("[%0d] unexpected row: x=%0d y=%0d mask=%h last=%0b",
                                 cycle_count, o_result.pixel_x, o_result.pixel_y,
                                 o_result.row_mask, o_result.last_row);
                end else begin
                    want = glyph_rows_due.pop_front();
                    if (o_result.pixel_x  !== want.pixel_x  ||
                        o_result.pixel_y  !== want.pixel_y  ||
                        o_result.row_mask !== want.row_mask ||
                        o_result.last_row !== want.last_row) begin
                        errors++;
                        if (errors <= MAX_SHOWN) begin
                            $display("[%0d] row mismatch: exp x=%0d y=%0d mask=%h last=%0b",
                                     cycle_count, want.pixel_x, want.pixel_y,
                                     want.row_mask, want.last_row);
                            $display("      got x=%0d y=%0d mask=%h last=%0b",
                                     o_result.pixel_x, o_result.pixel_y,
                                     o_result.row_mask, o_result.last_row);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A transaction on the port
    // is held until the monitor saw it taken; idle gaps come in random bursts.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || input_taken) begin
            if (send_gap > 0) begin
                push <= 1'b0;
                send_gap--;
            end else if (pending_items.size() != 0 &&
                         $urandom_range(0, 99) < send_idle_pct) begin
                push     <= 1'b0;
                send_gap = $urandom_range(1, 7) - 1;
            end else if (pending_items.size() != 0) begin
                i_item <= pending_items.pop_front();
                push   <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: pop high except during random stall bursts
    always @(negedge i_clk) begin : consumer
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            pop       <= 1'b0;
            pop_stall = $urandom_range(1, 7) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            grr_pkg::CFG_GLYPH_WIDTH:  width_reg  = data[4:0];
            grr_pkg::CFG_GLYPH_HEIGHT: height_reg = data[4:0];
            grr_pkg::CFG_SYMBOL_COUNT: count_reg  = data;
            default: ;  // unused index, no effect
        endcase
    endtask

    // random bits above the 5-bit fields must be dropped by the block
    task automatic set_config(int w, int h, int cnt);
        cfg_write(grr_pkg::CFG_GLYPH_WIDTH,  {4'($urandom), 5'(w)});
        cfg_write(grr_pkg::CFG_GLYPH_HEIGHT, {4'($urandom), 5'(h)});
        cfg_write(grr_pkg::CFG_SYMBOL_COUNT, 9'(cnt));
        cfg_write(CFG_UNUSED_INDEX, 9'($urandom));
        phases_run++;
    endtask

    task automatic queue_load(int code, int line, logic [15:0] bits);
        grr_pkg::t_in_item it;
        it.func       = grr_pkg::FUNC_LOAD;
        it.char_code  = 8'(code);
        it.cell_col   = 8'($urandom);
        it.cell_row   = 8'($urandom);
        it.glyph_line = 4'(line);
        it.line_bits  = bits;
        font_ready[code * MAX_H + line] = 1'b1;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // A valid render first gets loads for any glyph row it would read that
    // was never written; a skipped code needs none.
    task automatic queue_render(int code, int col, int row);
        grr_pkg::t_in_item it;
        if (code < eff_count()) begin
            for (int l = 0; l < eff_height(); l++)
                if (!font_ready[code * MAX_H + l]) queue_load(code, l, 16'($urandom));
        end
        it.func       = grr_pkg::FUNC_RENDER;
        it.char_code  = 8'(code);
        it.cell_col   = 8'(col);
        it.cell_row   = 8'(row);
        it.glyph_line = 4'($urandom);
        it.line_bits  = 16'($urandom);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Sender holds until every input is taken and every row has arrived,
    // then lets trailing loads drain before anything is reconfigured.
    task automatic wait_idle();
        @(posedge i_clk);
        while (items_accepted != items_queued || glyph_rows_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_config(output int w, output int h, output int cnt);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)      w = (r < 5) ? 0 : $urandom_range(17, 31);
        else             w = $urandom_range(1, 16);
        r = $urandom_range(0, 99);
        if (r < 10)      h = (r < 4) ? 0 : $urandom_range(17, 31);
        else if (r < 30) h = 16;
        else             h = $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (r < 8)       cnt = 0;
        else if (r < 20) cnt = $urandom_range(257, 511);
        else if (r < 35) cnt = 256;
        else             cnt = $urandom_range(1, 255);
    endtask

    // Mostly load-then-render sequences on a few reused glyphs, plus
    // stray loads and renders of codes past the symbol count.
    task automatic queue_random(int budget);
        int stop_at;
        int r;
        int limit;
        int code;
        stop_at = items_queued + budget;
        while (items_queued < stop_at) begin
            r     = $urandom_range(0, 99);
            limit = eff_count();
            if (r < 62 || (r >= 82 && limit == MAX_SYM)) begin
                if (limit == 0)
                    code = $urandom_range(0, 255);
                else if ($urandom_range(0, 1) == 1)
                    code = $urandom_range(0, ((limit < 12) ? limit : 12) - 1);
                else
                    code = $urandom_range(0, limit - 1);
                // sometimes rewrite a row of this glyph before drawing it
                if ($urandom_range(0, 4) == 0)
                    queue_load(code, $urandom_range(0, 15), 16'($urandom));
                queue_render(code, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (r < 82) begin
                queue_load($urandom_range(0, 255), $urandom_range(0, 15), 16'($urandom));
            end else begin
                queue_render($urandom_range(limit, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int w;
        int h;
        int cnt;
        for (int i = 0; i < MAX_SYM * MAX_H; i++) font_model[i] = 16'h0000;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 15;
        recv_idle_pct = 15;

        // directed: full width, two-row glyphs, all 256 codes valid;
        // corner codes and corner cells, all-ones and all-zeros rows
        set_config(16, 2, 256);
        queue_load(0, 0, 16'hFFFF);
        queue_load(0, 1, 16'h0000);
        queue_load(255, 0, 16'h8001);
        queue_load(255, 1, 16'hFFFF);
        queue_load(255, 15, 16'h5AA5);
        queue_render(0, 0, 0);
        queue_render(255, 255, 255);
        queue_render(0, 255, 0);
        queue_render(255, 0, 255);
        wait_idle();

        // one-pixel, one-row glyphs and a single valid code: higher codes drop
        set_config(1, 1, 1);
        queue_render(0, 7, 9);
        queue_render(1, 3, 3);
        queue_render(255, 255, 255);
        wait_idle();

        // zero width and height clamp up to one
        set_config(0, 0, 200);
        queue_render(0, 255, 255);
        queue_render(200, 1, 1);
        queue_render(199, 128, 64);
        wait_idle();

        // oversize values clamp to 16 x 16 and the full symbol range
        set_config(31, 31, 511);
        queue_render(255, 255, 255);
        wait_idle();

        // no valid symbols at all: every render drops
        set_config(16, 16, 0);
        queue_render(0, 0, 0);
        queue_render(128, 5, 5);
        wait_idle();

        // random phases; each phase boundary drains the block completely,
        // the last phase runs with no idling on either side
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick_config(w, h, cnt);
            if (p == RANDOM_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(0, 2) * 12;
                recv_idle_pct = $urandom_range(0, 2) * 12;
            end
            set_config(w, h, cnt);
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        if (glyph_rows_due.size() != 0) errors += glyph_rows_due.size();

        $display("ran %0d settings, %0d transactions in (%0d renders), %0d glyph rows checked",
                 phases_run, items_accepted, renders_sent, rows_checked);
        $display("mismatches or missing rows: %0d", errors);
        if (errors == 0) begin
            $display("** glyph_row_renderer_top: PASSED **");
        end else begin
            $display("** glyph_row_renderer_top: FAILED **");
        end
        $finish;
    end

endmodule
